>>> rtl/lfna_pkg.sv
// Package for the lowest free number allocator.
// Holds field widths, request and response codes, defaults and the FSM state type.
// No dependencies.
package lfna_pkg;

   // Field widths
   localparam int NUM_W    = 10;
   localparam int STATUS_W = 2;
   localparam int HINT_W   = 11;
   localparam int NUM_SPAN = 1 << NUM_W;

   // Default geometry of the bitmap
   localparam int WORD_BITS_DEF  = 64;
   localparam int WORD_COUNT_DEF = 16;

   // Request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_START,
      S_SCAN,
      S_ALLOC_FIN,
      S_FREE_DIV,
      S_FREE_RD,
      S_FREE_CHK,
      S_DONE
   } state_type;

endpackage

>>> rtl/lfna_if.sv
// Valid/ready channel interfaces for the allocator request and response.
// Depends on lfna_pkg for field widths.
interface lfna_req_if;
   import lfna_pkg::*;
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [NUM_W-1:0] free_number;

   modport source (output valid, output opcode, output free_number, input ready);
   modport sink   (input valid, input opcode, input free_number, output ready);
endinterface

interface lfna_rsp_if;
   import lfna_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NUM_W-1:0]    number;

   modport source (output valid, output status, output number, input ready);
   modport sink   (input valid, input status, input number, output ready);
endinterface

>>> rtl/lfna_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lfna_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lfna_ffz.sv
// Find-first-zero over one bitmap word: lowest clear bit index and a full flag.
// No dependencies.
module lfna_ffz #(
   parameter int WIDTH = 64,
   parameter int IDX_W = $clog2(WIDTH)
) (
   input  logic [WIDTH-1:0] word,
   output logic             all_ones,
   output logic [IDX_W-1:0] index
);

   logic [WIDTH-1:0] zeros;
   logic [WIDTH-1:0] lowest;

   // isolate the lowest clear bit as a one-hot vector
   assign zeros    = ~word;
   assign lowest   = zeros & (~zeros + WIDTH'(1));
   assign all_ones = (zeros == '0);

   // one-hot to binary: each index bit ORs the positions that carry it
   always_comb begin
      index = '0;
      for (int i = 0; i < WIDTH; i++) begin
         for (int k = 0; k < IDX_W; k++) begin
            if (((i >> k) & 1) == 1) begin
               index[k] = index[k] | lowest[i];
            end
         end
      end
   end

endmodule

>>> rtl/lowest_free_number_allocator.sv
// Lowest free number allocator: bitmap of used numbers in a RAM, scanned word by word.
// Depends on lfna_pkg, lfna_if, lfna_ram and lfna_ffz.
//
//   channel   dir   handshake     payload
//   req_bus   in    valid/ready   opcode, free_number
//   rsp_bus   out   valid/ready   status, number
//
// One request is handled at a time; the response sits in an output register so
// the next request can be taken while it waits.
// Allocate: start at the hint's word, scan to the first word with a clear bit
// (one bitmap RAM read per cycle), then grant. Free: split, read, update.
// Reset clears the bitmap through per-word valid bits; no clearing pass is needed.
// A stalled response holds the controller in its final state until it is taken.
module lowest_free_number_allocator #(
   parameter int WORD_BITS  = lfna_pkg::WORD_BITS_DEF,
   parameter int WORD_COUNT = lfna_pkg::WORD_COUNT_DEF
) (
   input logic         clock,
   input logic         reset,
   lfna_req_if.sink    req_bus,
   lfna_rsp_if.source  rsp_bus
);
   import lfna_pkg::*;

   // geometry: only words that can hold usable numbers are stored
   localparam int TOTAL       = WORD_BITS * WORD_COUNT;
   localparam int USABLE      = (TOTAL < NUM_SPAN) ? TOTAL : NUM_SPAN;
   localparam int SPAN_WORDS  = (NUM_SPAN + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH       = (WORD_COUNT < SPAN_WORDS) ? WORD_COUNT : SPAN_WORDS;
   localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HW          = $clog2(DEPTH + 1);
   localparam int BW          = $clog2(WORD_BITS);
   // number / WORD_BITS by reciprocal multiply, exact for 10-bit numbers
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int PROD_W      = NUM_W + RECIP_W;

   state_type state_ff, state_in;

   logic [HINT_W-1:0]   hint_ff, hint_in;
   logic [HW-1:0]       hint_word_ff, hint_word_in;
   logic [AW-1:0]       scan_w_ff, scan_w_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [AW-1:0]       fw_ff, fw_in;
   logic [BW-1:0]       fb_ff, fb_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [BW-1:0]       fbit_ff, fbit_in;
   logic [DEPTH-1:0]    valid_ff, valid_in;
   logic                rd_valid_ff;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [NUM_W-1:0]    res_number_ff, res_number_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [NUM_W-1:0]    rsp_number_ff, rsp_number_in;

   logic                 req_fire;
   logic                 out_free;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;
   logic [WORD_BITS-1:0] rdata_m;
   logic                 word_full;
   logic [BW-1:0]        zero_idx;
   logic [PROD_W-1:0]    div_prod;
   logic [HINT_W-1:0]    free_rem;
   logic [HINT_W-1:0]    alloc_num;

   // bitmap storage
   lfna_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH),
      .ADDR_W(AW)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // words never written since reset read as all free
   assign rdata_m = ram_rdata & {WORD_BITS{rd_valid_ff}};

   lfna_ffz #(
      .WIDTH(WORD_BITS),
      .IDX_W(BW)
   ) u_ffz (
      .word    (rdata_m),
      .all_ones(word_full),
      .index   (zero_idx)
   );

   // handshakes
   assign req_bus.ready  = (state_ff == S_IDLE);
   assign req_fire       = req_bus.valid && req_bus.ready;
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.number = rsp_number_ff;

   // arithmetic helpers
   assign div_prod  = PROD_W'(num_ff) * PROD_W'(RECIP);
   assign free_rem  = HINT_W'(num_ff) - HINT_W'(fw_ff) * HINT_W'(WORD_BITS);
   assign alloc_num = HINT_W'(scan_w_ff) * HINT_W'(WORD_BITS) + HINT_W'(fbit_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (req_bus.opcode == OP_FREE) ? S_FREE_DIV : S_ALLOC_START;
            end
         end
         S_ALLOC_START: begin
            state_in = (hint_word_ff >= HW'(DEPTH)) ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            if (!word_full) begin
               state_in = S_ALLOC_FIN;
            end else if (scan_w_ff == AW'(DEPTH - 1)) begin
               state_in = S_DONE;
            end
         end
         S_ALLOC_FIN: state_in = S_DONE;
         S_FREE_DIV:  state_in = S_FREE_RD;
         S_FREE_RD: begin
            state_in = (HINT_W'(num_ff) >= HINT_W'(USABLE)) ? S_DONE : S_FREE_CHK;
         end
         S_FREE_CHK:  state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      hint_in       = hint_ff;
      hint_word_in  = hint_word_ff;
      scan_w_in     = scan_w_ff;
      num_in        = num_ff;
      fw_in         = fw_ff;
      fb_in         = fb_ff;
      word_in       = word_ff;
      fbit_in       = fbit_ff;
      valid_in      = valid_ff;
      res_status_in = res_status_ff;
      res_number_in = res_number_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_number_in = rsp_number_ff;
      ram_we        = 1'b0;
      ram_waddr     = scan_w_ff;
      ram_wdata     = word_ff;
      ram_raddr     = fw_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               num_in = req_bus.free_number;
            end
         end
         // start the scan at the hint's word
         S_ALLOC_START: begin
            ram_raddr     = AW'(hint_word_ff);
            scan_w_in     = AW'(hint_word_ff);
            res_status_in = ST_FULL;
            res_number_in = '0;
         end
         // one word per cycle; the next word is fetched ahead
         S_SCAN: begin
            ram_raddr = scan_w_ff + AW'(1);
            word_in   = rdata_m;
            fbit_in   = zero_idx;
            if (word_full && scan_w_ff != AW'(DEPTH - 1)) begin
               scan_w_in = scan_w_ff + AW'(1);
            end
         end
         // grant the number unless it lies past the usable range
         S_ALLOC_FIN: begin
            if (alloc_num < HINT_W'(USABLE)) begin
               ram_we              = 1'b1;
               ram_waddr           = scan_w_ff;
               ram_wdata           = word_ff | (WORD_BITS'(1) << fbit_ff);
               valid_in[scan_w_ff] = 1'b1;
               hint_in             = alloc_num + HINT_W'(1);
               hint_word_in        = HW'(scan_w_ff) +
                                     HW'(fbit_ff == BW'(WORD_BITS - 1));
               res_status_in       = ST_OK;
               res_number_in       = NUM_W'(alloc_num);
            end
         end
         // word index of the freed number
         S_FREE_DIV: begin
            fw_in = AW'(div_prod >> RECIP_SHIFT);
         end
         // bit index, range check, fetch the word
         S_FREE_RD: begin
            ram_raddr     = fw_ff;
            fb_in         = free_rem[BW-1:0];
            res_status_in = ST_BADFREE;
            res_number_in = '0;
         end
         // clear the bit if it was set; pull the hint down
         S_FREE_CHK: begin
            if (rdata_m[fb_ff]) begin
               ram_we          = 1'b1;
               ram_waddr       = fw_ff;
               ram_wdata       = rdata_m & ~(WORD_BITS'(1) << fb_ff);
               valid_in[fw_ff] = 1'b1;
               res_status_in   = ST_OK;
               if (HINT_W'(num_ff) < hint_ff) begin
                  hint_in      = HINT_W'(num_ff);
                  hint_word_in = HW'(fw_ff);
               end
            end
         end
         // hand the result to the output register
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_number_in = res_number_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hint_ff      <= '0;
         hint_word_ff <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hint_ff      <= hint_in;
         hint_word_ff <= hint_word_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_w_ff     <= scan_w_in;
      num_ff        <= num_in;
      fw_ff         <= fw_in;
      fb_ff         <= fb_in;
      word_ff       <= word_in;
      fbit_ff       <= fbit_in;
      rd_valid_ff   <= valid_ff[ram_raddr];
      res_status_ff <= res_status_in;
      res_number_ff <= res_number_in;
      rsp_status_ff <= rsp_status_in;
      rsp_number_ff <= rsp_number_in;
   end

endmodule
